// ===== hdl/ekct_pkg.sv =====
// Shared types and constants for the error key counting table.
`default_nettype none

package ekct_pkg;

  localparam int unsigned FP_W   = 64;
  localparam int unsigned CC_W   = 30;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned TIME_W = 64;

  localparam logic [1:0] ST_IGNORED = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_CREATED = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  typedef struct packed {
    logic key_we;
    logic cnt_we;
  } entry_wr_t;

endpackage

`default_nettype wire

// ===== hdl/error_key_counting_table.sv =====
// Top level of the error key counting table: sequencer, key compare and stream ports.
//
//   Channel  Direction  tdata fields, lowest bit first
//   s_axis   in         fingerprint[63:0], class_code[93:64], event_time[157:94]
//   m_axis   out        status[1:0], entry_index[7:2], new_count[39:8], entries_in_use[46:40]
//
// An event whose fingerprint or class code is zero is answered as ignored without a scan.
// Other events are compared against one stored entry per cycle through a single
// key comparator fed by the registered read port of the entry store: a hit ends
// the scan at that entry, a miss ends it after the n entries in use, and the next
// event is accepted only after the result has been loaded into the output register.
// Reset clears only the fill count and control state; no clearing pass is run.
// The input is not ready while an event is in progress; a result waiting in the
// output register stalls the loading of the next result, but not its scan.
`default_nettype none

module error_key_counting_table #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // fingerprint, class_code, event_time, two unused bits
  input  wire [159:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // status, entry_index, new_count, entries_in_use, one zero bit
  output logic [47:0] m_axis_tdata_o
);

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [FILL_W-1:0]              fill_q, fill_d;
  logic [FILL_W-1:0]              scan_q, scan_d;
  logic                           cmp_valid_q, cmp_valid_d;
  logic [IDX_W-1:0]               cmp_idx_q;
  logic [ekct_pkg::FP_W-1:0]      fp_q;
  logic [ekct_pkg::CC_W-1:0]      cc_q;
  logic [ekct_pkg::TIME_W-1:0]    time_q;
  logic [1:0]                     res_status_q, res_status_d;
  logic [IDX_W-1:0]               res_idx_q, res_idx_d;
  logic [ekct_pkg::CNT_W-1:0]     res_cnt_q, res_cnt_d;
  logic                           out_valid_q;
  logic [47:0]                    out_data_q;

  logic [ekct_pkg::FP_W-1:0]      in_fp;
  logic [ekct_pkg::CC_W-1:0]      in_cc;
  logic                           accept;
  logic                           hit;
  logic                           scan_end;
  logic                           rd_en;
  logic                           out_load;
  logic [ekct_pkg::FP_W-1:0]      rd_fp;
  logic [ekct_pkg::CC_W-1:0]      rd_cc;
  logic [ekct_pkg::CNT_W-1:0]     rd_cnt;
  logic [ekct_pkg::CNT_W-1:0]     inc_cnt;
  ekct_pkg::entry_wr_t            wr;
  logic [IDX_W-1:0]               wr_addr;
  logic [ekct_pkg::CNT_W-1:0]     wr_cnt;
  logic [IDX_W+5:0]               idx_ext;
  logic [FILL_W+6:0]              fill_ext;

  assign in_fp  = s_axis_tdata_i[63:0];
  assign in_cc  = s_axis_tdata_i[93:64];
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == S_IDLE);

  assign hit      = (state_q == S_SCAN) && cmp_valid_q && (rd_fp == fp_q) && (rd_cc == cc_q);
  assign scan_end = (state_q == S_SCAN) && !hit && (scan_q == fill_q);
  assign rd_en    = (state_q == S_SCAN) && !hit && (scan_q != fill_q);
  assign inc_cnt  = rd_cnt + ekct_pkg::CNT_W'(1);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    scan_d       = scan_q;
    cmp_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_cnt_d    = res_cnt_q;
    wr           = '0;
    wr_addr      = cmp_idx_q;
    wr_cnt       = inc_cnt;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          scan_d = '0;
          if ((in_fp == '0) || (in_cc == '0)) begin
            res_status_d = ekct_pkg::ST_IGNORED;
            res_idx_d    = '0;
            res_cnt_d    = '0;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          wr.cnt_we    = 1'b1;
          res_status_d = ekct_pkg::ST_UPDATED;
          res_idx_d    = cmp_idx_q;
          res_cnt_d    = inc_cnt;
          state_d      = S_DONE;
        end else if (scan_end) begin
          if (fill_q != FILL_MAX) begin
            wr.key_we    = 1'b1;
            wr.cnt_we    = 1'b1;
            wr_addr      = fill_q[IDX_W-1:0];
            wr_cnt       = ekct_pkg::CNT_W'(1);
            fill_d       = fill_q + FILL_W'(1);
            res_status_d = ekct_pkg::ST_CREATED;
            res_idx_d    = fill_q[IDX_W-1:0];
            res_cnt_d    = ekct_pkg::CNT_W'(1);
          end else begin
            res_status_d = ekct_pkg::ST_DROPPED;
            res_idx_d    = '0;
            res_cnt_d    = '0;
          end
          state_d = S_DONE;
        end else begin
          cmp_valid_d = 1'b1;
          scan_d      = scan_q + FILL_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      scan_q      <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      cmp_valid_q <= cmp_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign idx_ext  = {6'd0, res_idx_q};
  assign fill_ext = {7'd0, fill_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fp_q   <= in_fp;
      cc_q   <= in_cc;
      time_q <= s_axis_tdata_i[157:94];
    end
    if (rd_en) begin
      cmp_idx_q <= scan_q[IDX_W-1:0];
    end
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_cnt_q    <= res_cnt_d;
    if (out_load) begin
      out_data_q <= {1'b0, fill_ext[6:0], res_cnt_q, idx_ext[5:0], res_status_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  ekct_entry_mem #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_entry_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_q[IDX_W-1:0]),
    .rd_fp_o   (rd_fp),
    .rd_cc_o   (rd_cc),
    .rd_cnt_o  (rd_cnt),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .wr_fp_i   (fp_q),
    .wr_cc_i   (cc_q),
    .wr_cnt_i  (wr_cnt),
    .wr_time_i (time_q)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("Fill count exceeds the table size.");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_q <= fill_q))
    else $error("Scan pointer ran past the filled entries.");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.key_we |=> (fill_q == $past(fill_q) + FILL_W'(1)))
    else $error("A new entry did not advance the fill count.");

  a_key_wr_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.key_we || wr.cnt_we) |-> (state_q == S_SCAN))
    else $error("Entry store written outside a scan.");

  a_new_count_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_status_q == ekct_pkg::ST_CREATED)) |-> (res_cnt_q == 32'd1))
    else $error("A newly created entry does not report a count of one.");
`endif

endmodule

`default_nettype wire

// ===== hdl/ekct_entry_mem.sv =====
// Entry store holding the key pairs, counts and last timestamps of the table.
`default_nettype none

module ekct_entry_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  wire                             clk_i,
  input  wire                             rd_en_i,
  input  wire  [IDX_W-1:0]                rd_addr_i,
  output logic [ekct_pkg::FP_W-1:0]       rd_fp_o,
  output logic [ekct_pkg::CC_W-1:0]       rd_cc_o,
  output logic [ekct_pkg::CNT_W-1:0]      rd_cnt_o,
  input  wire  ekct_pkg::entry_wr_t       wr_i,
  input  wire  [IDX_W-1:0]                wr_addr_i,
  input  wire  [ekct_pkg::FP_W-1:0]       wr_fp_i,
  input  wire  [ekct_pkg::CC_W-1:0]       wr_cc_i,
  input  wire  [ekct_pkg::CNT_W-1:0]      wr_cnt_i,
  input  wire  [ekct_pkg::TIME_W-1:0]     wr_time_i
);

  logic [ekct_pkg::FP_W+ekct_pkg::CC_W-1:0] key_mem  [DEPTH];
  logic [ekct_pkg::CNT_W-1:0]               cnt_mem  [DEPTH];
  logic [ekct_pkg::TIME_W-1:0]              time_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem[wr_addr_i] <= {wr_cc_i, wr_fp_i};
    end
    if (wr_i.cnt_we) begin
      cnt_mem[wr_addr_i]  <= wr_cnt_i;
      time_mem[wr_addr_i] <= wr_time_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      {rd_cc_o, rd_fp_o} <= key_mem[rd_addr_i];
      rd_cnt_o           <= cnt_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire
